[design/ntp_pkg.sv]
// ----------------------------------------------------------------------------
// ntp_pkg
// Shared types, codes and helpers of the number text parser.
// ----------------------------------------------------------------------------
package ntp_pkg;

  localparam int unsigned AccW = 64;
  localparam int unsigned ChrW = 8;

  typedef logic [AccW-1:0] acc_t;
  typedef logic [ChrW-1:0] chr_t;
  typedef logic [2:0]      phase_t;
  typedef logic [1:0]      unit_t;

  // parse phases
  localparam phase_t PH_START  = 3'd0;
  localparam phase_t PH_ZERO   = 3'd1;
  localparam phase_t PH_HEX    = 3'd2;
  localparam phase_t PH_OCT    = 3'd3;
  localparam phase_t PH_DEC    = 3'd4;
  localparam phase_t PH_SUFFIX = 3'd5;
  localparam phase_t PH_IGNORE = 3'd6;

  // size units
  localparam unit_t UNIT_NONE = 2'd0;
  localparam unit_t UNIT_K    = 2'd1;
  localparam unit_t UNIT_M    = 2'd2;
  localparam unit_t UNIT_G    = 2'd3;

  localparam chr_t CHR_NUL = 8'h00;
  localparam chr_t CHR_0   = 8'h30;
  localparam chr_t CHR_LB  = 8'h62;  // 'b'
  localparam chr_t CHR_UB  = 8'h42;  // 'B'

  // x * 1000 as shift-add: 1024 - 16 - 8
  function automatic acc_t mul1000(input acc_t a);
    mul1000 = (a << 10) - (a << 4) - (a << 3);
  endfunction

  // x << 10, 20 or 30 by unit
  function automatic acc_t scale_bin(input acc_t a, input unit_t u);
    case (u)
      UNIT_K:  scale_bin = a << 10;
      UNIT_M:  scale_bin = a << 20;
      UNIT_G:  scale_bin = a << 30;
      default: scale_bin = a;
    endcase
  endfunction

endpackage

[design/number_text_parser_top.sv]
// ----------------------------------------------------------------------------
// number_text_parser_top
// Streaming parser of unsigned 64-bit numbers with radix prefix and size
// suffix, one character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_character) carries one string
//   byte per beat; a zero byte ends the string. Decimal, octal (leading 0)
//   and hex (0x / 0X) forms are parsed, followed by an optional k, m or g.
//   A following b scales by 1000^n, a B or the end scales by 2^(10n).
//   Output channel (out_valid / out_ready / out_value / out_malformed)
//   carries one beat per terminator; malformed strings give value zero.
// Flow and throughput:
//   A character is captured in the input register when it is accepted and
//   is then folded into the parse state; a terminator's result lands in
//   the output register, which drives out_valid. One character is taken
//   per cycle while no terminator waits in the input register. The decimal
//   b scale runs one x1000 shift-add step per cycle (1 to 3 steps); a
//   terminator arriving during those steps waits there until they finish.
// Reset and stall:
//   rst_n (synchronous) returns the parser to its start state and empties
//   both registers. When the receiver stalls, the output register holds its
//   beat; characters keep flowing until a terminator needs the output slot.
// ----------------------------------------------------------------------------
module number_text_parser_top
  import ntp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_character,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_value,
  output logic        out_malformed
);

  // input register
  logic   s0_vld_r;
  chr_t   s0_chr_r;

  // parse state
  phase_t phase_r, phase_nxt;
  acc_t   acc_r, acc_nxt;
  unit_t  unit_r, unit_nxt;
  logic   err_r, err_nxt;
  unit_t  cnt_r, cnt_nxt;   // remaining x1000 steps

  // output register
  logic   out_vld_r;
  acc_t   out_val_r, out_val_nxt;
  logic   out_mal_r, out_mal_nxt;

  logic   term;
  logic   out_free;
  logic   s0_fire;
  logic   is_dec, is_oct, is_hex_lc, is_hex_uc, is_x;
  unit_t  sfx;
  logic [3:0] dig;

  // --- character classes ---------------------------------------------------
  assign term      = (s0_chr_r == CHR_NUL);
  assign is_dec    = s0_chr_r inside {[8'h30:8'h39]};
  assign is_oct    = s0_chr_r inside {[8'h30:8'h37]};
  assign is_hex_lc = s0_chr_r inside {[8'h61:8'h66]};
  assign is_hex_uc = s0_chr_r inside {[8'h41:8'h46]};
  assign is_x      = s0_chr_r inside {8'h78, 8'h58};

  // digit value: low nibble for 0-9, low nibble + 9 for a-f / A-F
  assign dig = is_dec ? s0_chr_r[3:0] : 4'(s0_chr_r[3:0] + 4'd9);

  always_comb begin
    case (s0_chr_r)
      8'h6b, 8'h4b: sfx = UNIT_K;
      8'h6d, 8'h4d: sfx = UNIT_M;
      8'h67, 8'h47: sfx = UNIT_G;
      default:      sfx = UNIT_NONE;
    endcase
  end

  // --- handshake -----------------------------------------------------------
  // A terminator needs a free output slot and no pending scale steps;
  // any other character advances at once.
  assign out_free = !out_vld_r || out_ready;
  assign s0_fire  = s0_vld_r && (!term || (cnt_r == UNIT_NONE && out_free));
  assign in_ready = !s0_vld_r || s0_fire;

  // --- parse step ----------------------------------------------------------
  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    unit_nxt    = unit_r;
    err_nxt     = err_r;
    cnt_nxt     = cnt_r;
    out_val_nxt = out_val_r;
    out_mal_nxt = out_mal_r;

    // advance the decimal scale, one x1000 per cycle
    if (cnt_r != UNIT_NONE) begin
      acc_nxt = mul1000(acc_r);
      cnt_nxt = unit_t'(cnt_r - 2'd1);
    end

    if (s0_fire) begin
      if (term) begin
        // emit the result and drop back to the start state
        if (err_r || phase_r == PH_START) begin
          out_val_nxt = '0;
          out_mal_nxt = 1'b1;
        end else if (phase_r == PH_SUFFIX) begin
          out_val_nxt = scale_bin(acc_r, unit_r);
          out_mal_nxt = 1'b0;
        end else begin
          out_val_nxt = acc_r;
          out_mal_nxt = 1'b0;
        end
        phase_nxt = PH_START;
        acc_nxt   = '0;
        unit_nxt  = UNIT_NONE;
        err_nxt   = 1'b0;
        cnt_nxt   = UNIT_NONE;
      end else begin
        case (phase_r)
          PH_START: begin
            if (s0_chr_r == CHR_0) begin
              phase_nxt = PH_ZERO;
            end else if (is_dec) begin
              acc_nxt   = acc_t'(dig);
              phase_nxt = PH_DEC;
            end else begin
              err_nxt   = 1'b1;
              phase_nxt = PH_IGNORE;
            end
          end
          PH_ZERO, PH_HEX, PH_OCT, PH_DEC: begin
            if (phase_r == PH_ZERO && is_x) begin
              phase_nxt = PH_HEX;
            end else if (phase_r == PH_ZERO && is_oct) begin
              acc_nxt   = acc_t'(dig);
              phase_nxt = PH_OCT;
            end else if (phase_r == PH_HEX && (is_dec || is_hex_lc || is_hex_uc)) begin
              acc_nxt = (acc_r << 4) + acc_t'(dig);
            end else if (phase_r == PH_OCT && is_oct) begin
              acc_nxt = (acc_r << 3) + acc_t'(dig);
            end else if (phase_r == PH_DEC && is_dec) begin
              acc_nxt = (acc_r << 3) + (acc_r << 1) + acc_t'(dig);
            end else if (sfx != UNIT_NONE) begin
              unit_nxt  = sfx;
              phase_nxt = PH_SUFFIX;
            end else begin
              err_nxt   = 1'b1;
              phase_nxt = PH_IGNORE;
            end
          end
          PH_SUFFIX: begin
            if (s0_chr_r == CHR_LB) begin
              cnt_nxt   = unit_r;          // start the x1000 steps
              phase_nxt = PH_IGNORE;
            end else if (s0_chr_r == CHR_UB) begin
              acc_nxt   = scale_bin(acc_r, unit_r);
              phase_nxt = PH_IGNORE;
            end else begin
              err_nxt   = 1'b1;
              phase_nxt = PH_IGNORE;
            end
          end
          default: begin
            phase_nxt = PH_IGNORE;       // drop everything until the end
          end
        endcase
      end
    end
  end

  // --- registers -----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_START;
      acc_r     <= '0;
      unit_r    <= UNIT_NONE;
      err_r     <= 1'b0;
      cnt_r     <= UNIT_NONE;
    end else begin
      if (in_ready) begin
        s0_vld_r <= in_valid;
      end
      if (s0_fire && term) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      unit_r  <= unit_nxt;
      err_r   <= err_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_chr_r <= in_character;
    end
    out_val_r <= out_val_nxt;
    out_mal_r <= out_mal_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_value     = out_val_r;
  assign out_malformed = out_mal_r;

  // --- assertions ----------------------------------------------------------
  a_scale_in_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != UNIT_NONE |-> phase_r == PH_IGNORE)
    else $error("scale steps pending outside the ignore phase");

  a_scale_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != UNIT_NONE |=> cnt_r == unit_t'($past(cnt_r) - 2'd1))
    else $error("scale step counter did not advance");

  a_err_in_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> phase_r == PH_IGNORE)
    else $error("error flag set outside the ignore phase");

  a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_mal_r |-> out_val_r == '0)
    else $error("malformed result with nonzero value");

  a_term_waits_scale: assert property (@(posedge clk) disable iff (!rst_n)
    s0_vld_r && term && cnt_r != UNIT_NONE |=> s0_vld_r && term)
    else $error("terminator left the input register during scaling");

endmodule
